// File: hdl/pjt_pkg.sv
// Package for the periodic job timer: sizes, codes, types and helpers.
// No dependencies; pjt_scan and periodic_job_timer_core import it, pjt_ram does not.
package pjt_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int DL_W   = 40;  // deadline and tick counter
  localparam int PRD_W  = 32;  // job period
  localparam int SLOT_W = 4;   // slot field of a result
  localparam int KIND_W = 2;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [DL_W-1:0] DL_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FIRE
  } state_e;

  // one evaluated memory entry, towards the minimum tracker
  typedef struct packed {
    logic             vld;
    logic             qual;
    logic [IDX_W-1:0] idx;
    logic [DL_W-1:0]  dl;
  } scan_in_t;

  // running best of a scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [DL_W-1:0]  dl;
  } best_t;

  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0]  a,
                                              input logic [PRD_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {{(DL_W+1-PRD_W){1'b0}}, b};
    return s[DL_W] ? DL_MAX : s[DL_W-1:0];
  endfunction

  // slot number masked to the result field
  function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] t;
    t = (IDX_W + SLOT_W)'(idx);
    return t[SLOT_W-1:0];
  endfunction

endpackage

// File: hdl/pjt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the deadline and period tables.
module pjt_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pjt_scan.sv
// Minimum tracker: keeps the earliest qualifying deadline seen during a scan.
// Depends on pjt_pkg.
module pjt_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  pjt_pkg::scan_in_t ent_i,
  output pjt_pkg::best_t    best_o
);
  import pjt_pkg::*;

  logic             found_q;
  logic [IDX_W-1:0] idx_q;
  logic [DL_W-1:0]  dl_q;
  logic             take;

  // strict compare: entries come in ascending slot order, so ties keep the lower slot
  assign take = !clr_i && ent_i.vld && ent_i.qual && (!found_q || (ent_i.dl < dl_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q <= ent_i.idx;
      dl_q  <= ent_i.dl;
    end
  end

  assign best_o = '{found: found_q, idx: idx_q, dl: dl_q};

endmodule

// File: hdl/periodic_job_timer_core.sv
// Periodic job timer top level: control sequencer, slot bookkeeping, result register.
// Depends on pjt_pkg, pjt_ram and pjt_scan.
//
// A register command leaves busy low and its result appears on the next cycle. A tick
// holds busy while it scans: each fired job costs one full pass of the deadline
// memory's single read port, one slot per cycle, to find the earliest due job.
// Every result is shown for exactly one cycle with valid_o high and must be taken
// then; last_o marks the final result of a command.
module periodic_job_timer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd_i,
  input  logic [pjt_pkg::PRD_W-1:0]  interval_i,
  output logic                       valid_o,
  output logic [pjt_pkg::KIND_W-1:0] kind_o,
  output logic [pjt_pkg::SLOT_W-1:0] slot_o,
  output logic [pjt_pkg::DL_W-1:0]   due_time_o,
  output logic                       last_o
);
  import pjt_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   scan_idx_q;
  logic               eval_vld_q;
  logic [IDX_W-1:0]   eval_idx_q;
  logic               first_q;
  logic [SLOTS-1:0]   pending_q;
  logic [CNT_W-1:0]   pend_cnt_q;
  logic [FCNT_W-1:0]  fired_q;
  logic [SLOTS-1:0]   used_q;
  logic [DL_W-1:0]    now_q;

  logic               valid_q, valid_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [DL_W-1:0]    due_q, due_d;
  logic               last_q, last_d;

  logic               tick_go, reg_go, idle_go, fire_go, fire_last;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [DL_W-1:0]    reg_dl;
  logic [DL_W-1:0]    dl_rdata;
  logic [PRD_W-1:0]   prd_rdata;
  logic               dl_we;
  logic [IDX_W-1:0]   dl_waddr;
  logic [DL_W-1:0]    dl_wdata;
  logic               qual;
  scan_in_t           ent;
  best_t              best;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign reg_dl = sat_add(now_q, interval_i);

  // first pass of a tick decides which slots are due; later passes reuse that set
  assign qual = first_q ? (used_q[eval_idx_q] && (dl_rdata <= now_q))
                        : pending_q[eval_idx_q];
  assign ent  = '{vld: eval_vld_q, qual: qual, idx: eval_idx_q, dl: dl_rdata};

  assign fire_last = (pend_cnt_q == CNT_W'(1)) || (fired_q == FCNT_W'(MAX_RESULTS - 1));

  always_comb begin
    state_d = state_q;
    tick_go = 1'b0;
    reg_go  = 1'b0;
    idle_go = 1'b0;
    fire_go = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_TICK) begin
            tick_go = 1'b1;
            state_d = ST_SCAN;
          end else begin
            reg_go = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (best.found) begin
          state_d = ST_FIRE;
        end else begin
          idle_go = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIRE: begin
        fire_go = 1'b1;
        state_d = fire_last ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result payload
  always_comb begin
    valid_d = reg_go || idle_go || fire_go;
    kind_d  = KIND_IDLE;
    slot_d  = '0;
    due_d   = '0;
    last_d  = 1'b1;
    priority if (fire_go) begin
      kind_d = KIND_FIRED;
      slot_d = slot_out(best.idx);
      due_d  = best.dl;
      last_d = fire_last;
    end else if (reg_go && free_found) begin
      kind_d = KIND_REG;
      slot_d = slot_out(free_idx);
      due_d  = reg_dl;
    end else if (reg_go) begin
      kind_d = KIND_FULL;
    end else begin
      kind_d = KIND_IDLE;
    end
  end

  // deadline write-back never overlaps a scan read: writes happen only in idle or fire
  assign dl_we    = (reg_go && free_found) || fire_go;
  assign dl_waddr = fire_go ? best.idx : free_idx;
  assign dl_wdata = fire_go ? sat_add(best.dl, prd_rdata) : reg_dl;

  pjt_ram #(.WIDTH(DL_W), .DEPTH(SLOTS)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (scan_idx_q),
    .rdata_o (dl_rdata)
  );

  // period read of the winner is issued in decide, used in fire
  pjt_ram #(.WIDTH(PRD_W), .DEPTH(SLOTS)) u_prd_ram (
    .clk_i   (clk_i),
    .we_i    (reg_go && free_found),
    .waddr_i (free_idx),
    .wdata_i (interval_i),
    .raddr_i (best.idx),
    .rdata_o (prd_rdata)
  );

  pjt_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (tick_go || fire_go),
    .ent_i  (ent),
    .best_o (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      eval_vld_q <= 1'b0;
      eval_idx_q <= '0;
      first_q    <= 1'b0;
      pending_q  <= '0;
      pend_cnt_q <= '0;
      fired_q    <= '0;
      used_q     <= '0;
      now_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      eval_vld_q <= (state_q == ST_SCAN);
      eval_idx_q <= scan_idx_q;

      if (tick_go || fire_go) begin
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end

      if (tick_go) begin
        now_q      <= sat_add(now_q, PRD_W'(1));
        first_q    <= 1'b1;
        pending_q  <= '0;
        pend_cnt_q <= '0;
        fired_q    <= '0;
      end else begin
        if (state_q == ST_DECIDE) begin
          first_q <= 1'b0;
        end
        if (eval_vld_q && first_q) begin
          pending_q[eval_idx_q] <= qual;
          pend_cnt_q            <= pend_cnt_q + CNT_W'(qual);
        end
        if (fire_go) begin
          pending_q[best.idx] <= 1'b0;
          pend_cnt_q          <= pend_cnt_q - CNT_W'(1);
          fired_q             <= fired_q + FCNT_W'(1);
        end
      end

      if (reg_go && free_found) begin
        used_q[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    slot_q <= slot_d;
    due_q  <= due_d;
    last_q <= last_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign kind_o     = kind_q;
  assign slot_o     = slot_q;
  assign due_time_o = due_q;
  assign last_o     = last_q;

  // pending count tracks the pending set
  a_pend_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pending_q) == int'(pend_cnt_q))
    else $error("pending count out of step with pending set");

  // only fired results can be followed by more of the same transaction
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (kind_o == KIND_FIRED))
    else $error("non-final result is not a fired job");

  // fire is reached only with a winner
  a_fire_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE) |-> best.found)
    else $error("fire without a due slot");

  // busy rises only after an accepted tick
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (cmd_i == CMD_TICK)))
    else $error("busy raised without a tick");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for periodic_job_timer_core: registers jobs, ticks the
// tick counter and checks every answer against a behavioural job table.
// Depends on pjt_pkg and the RTL under hdl/.
module tb;
  import pjt_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYC   = 9;
  localparam int RANDOM_CMDS = 325;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * (SLOTS + 3);
  localparam int PRINT_CAP   = 40;

  typedef struct {
    cmd_e             cmd;
    logic [PRD_W-1:0] interval;
    int               gap;
    bit               drain;
  } timer_cmd_t;

  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [DL_W-1:0]   due;
    logic              last;
  } timer_answer_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cmd_i;
  logic [PRD_W-1:0]    interval_i;
  logic                valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [SLOT_W-1:0]   slot_o;
  logic [DL_W-1:0]     due_time_o;
  logic                last_o;

  periodic_job_timer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .interval_i (interval_i),
    .valid_o    (valid_o),
    .kind_o     (kind_o),
    .slot_o     (slot_o),
    .due_time_o (due_time_o),
    .last_o     (last_o)
  );

  timer_cmd_t    cmd_fifo[$];
  timer_answer_t answer_q[$];
  timer_cmd_t    next_cmd;
  timer_answer_t want;

  // behavioural job table
  logic [DL_W-1:0]  now_tk;
  logic             job_used   [SLOTS];
  logic [DL_W-1:0]  job_due    [SLOTS];
  logic [PRD_W-1:0] job_period [SLOTS];

  int n_accepted = 0;
  int n_driven   = 0;
  int n_checked  = 0;
  int errors     = 0;
  int cycle_cnt  = 0;
  int gap_left   = 0;
  int total_cmds = 0;
  int n_reg      = 0;
  int n_full     = 0;
  int n_ticks    = 0;
  int n_idle     = 0;
  int n_fired    = 0;
  bit burst      = 1'b0;
  logic hold_start;

  function automatic logic [DL_W-1:0] deadline_add(input logic [DL_W-1:0]  base,
                                                   input logic [PRD_W-1:0] step);
    logic [DL_W:0] sum;
    sum = {1'b0, base} + {{(DL_W+1-PRD_W){1'b0}}, step};
    return sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];
  endfunction

  function automatic void push_answer(input kind_e k, input int slot,
                                      input logic [DL_W-1:0] due, input logic last);
    timer_answer_t a;
    a.kind = k;
    a.slot = slot[SLOT_W-1:0];
    a.due  = due;
    a.last = last;
    answer_q.push_back(a);
  endfunction

  function automatic void add_cmd(input cmd_e cmd, input logic [PRD_W-1:0] interval,
                                  input bit drain);
    timer_cmd_t c;
    c.cmd      = cmd;
    c.interval = interval;
    c.gap      = burst ? 0 : $urandom_range(0, 7);
    c.drain    = drain;
    cmd_fifo.push_back(c);
  endfunction

  task automatic predict_timer_answers(input logic cmd, input logic [PRD_W-1:0] interval);
    int            free_slot;
    int            best;
    int            fired;
    bit            due_now [SLOTS];
    timer_answer_t tail;
    if (cmd == CMD_REGISTER) begin
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!job_used[i]) free_slot = i;
      if (free_slot < 0) begin
        push_answer(KIND_FULL, 0, '0, 1'b1);
        n_full++;
      end else begin
        job_used[free_slot]   = 1'b1;
        job_period[free_slot] = interval;
        job_due[free_slot]    = deadline_add(now_tk, interval);
        push_answer(KIND_REG, free_slot, job_due[free_slot], 1'b1);
        n_reg++;
      end
    end else begin
      n_ticks++;
      now_tk = deadline_add(now_tk, PRD_W'(1));
      for (int i = 0; i < SLOTS; i++)
        due_now[i] = job_used[i] && (job_due[i] <= now_tk);
      // earliest deadline first, lower slot wins a tie
      fired = 0;
      best  = 0;
      while (fired < MAX_RESULTS && best >= 0) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (due_now[i] && (best < 0 || job_due[i] < job_due[best])) best = i;
        if (best >= 0) begin
          due_now[best] = 1'b0;
          push_answer(KIND_FIRED, best, job_due[best], 1'b0);
          job_due[best] = deadline_add(job_due[best], job_period[best]);
          fired++;
        end
      end
      if (fired == 0) begin
        push_answer(KIND_IDLE, 0, '0, 1'b1);
        n_idle++;
      end else begin
        tail      = answer_q[$];
        tail.last = 1'b1;
        answer_q[$] = tail;
        n_fired += fired;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("end of test: mismatches");
    $finish;
  end

  // driver: one transaction at a time, a random gap ahead of each but the first outside bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      hold_start = start;
      if (n_accepted != n_driven) begin
        n_driven   = n_accepted;
        hold_start = 1'b0;
        gap_left   = (cmd_fifo.size() > 0) ? cmd_fifo[0].gap : 0;
      end
      if (!hold_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_fifo.size() > 0 && !(cmd_fifo[0].drain && answer_q.size() != 0)) begin
          next_cmd   = cmd_fifo.pop_front();
          cmd_i      <= next_cmd.cmd;
          interval_i <= next_cmd.interval;
          hold_start = 1'b1;
        end
        if (!hold_start) begin
          cmd_i      <= 1'($urandom);
          interval_i <= $urandom;
        end
      end
      start <= hold_start;
    end
  end

  // monitor: predict on acceptance, check every strobed answer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_timer_answers(cmd_i, interval_i);
        n_accepted++;
      end
      if (valid_o !== 1'b0) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("unexpected answer kind %0d slot %0d due %0d",
                                    kind_o, slot_o, due_time_o));
        end else begin
          want = answer_q.pop_front();
          n_checked++;
          if (kind_o !== want.kind)
            report_mismatch($sformatf("answer %0d kind %0d, want %0d",
                                      n_checked, kind_o, want.kind));
          if (slot_o !== want.slot)
            report_mismatch($sformatf("answer %0d slot %0d, want %0d",
                                      n_checked, slot_o, want.slot));
          if (due_time_o !== want.due)
            report_mismatch($sformatf("answer %0d due_time %0d, want %0d",
                                      n_checked, due_time_o, want.due));
          if (last_o !== want.last)
            report_mismatch($sformatf("answer %0d last %0b, want %0b",
                                      n_checked, last_o, want.last));
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = 1'b0;
    interval_i = '0;
    now_tk     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      job_used[i]   = 1'b0;
      job_due[i]    = '0;
      job_period[i] = '0;
    end

    // directed: idle tick, zero and all-ones periods, a deadline tie, filling
    // the table, then registrations against a full table
    add_cmd(CMD_TICK, 32'h0, 1'b0);
    add_cmd(CMD_REGISTER, 32'h0, 1'b0);
    add_cmd(CMD_REGISTER, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_REGISTER, 32'h1, 1'b0);
    add_cmd(CMD_REGISTER, 32'h1, 1'b0);
    add_cmd(CMD_REGISTER, 32'h3, 1'b0);
    add_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_TICK, 32'h0, 1'b0);
    add_cmd(CMD_TICK, 32'h5A5A_A5A5, 1'b1);
    burst = 1'b1;
    for (int k = 0; k < SLOTS - 5; k++)
      add_cmd(CMD_REGISTER, PRD_W'((k * 5 + 2) % 8), 1'b0);
    burst = 1'b0;
    add_cmd(CMD_REGISTER, 32'h8000_0000, 1'b0);
    add_cmd(CMD_REGISTER, 32'h7FFF_FFFF, 1'b1);
    for (int k = 0; k < 3; k++)
      add_cmd(CMD_TICK, $urandom, 1'b0);

    // random: mostly ticks on a busy table, alternating bursts and gappy stretches
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      burst = ((n / 40) % 2) == 1;
      if ($urandom_range(0, 9) < 8)
        add_cmd(CMD_TICK, $urandom, $urandom_range(0, 39) == 0);
      else
        add_cmd(CMD_REGISTER, $urandom, $urandom_range(0, 39) == 0);
    end
    total_cmds = cmd_fifo.size();

    repeat (RESET_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total_cmds || answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d transactions: %0d registered, %0d refused as full, %0d ticks",
             total_cmds, n_reg, n_full, n_ticks);
    $display("ticks fired %0d jobs, %0d ticks were idle, %0d answers checked, %0d errors",
             n_fired, n_idle, n_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
